/* design/wrp_pkg.sv */
`default_nettype none

package wrp_pkg;

    // Width of the running byte offset; the offset saturates at all ones.
    localparam int OFFSET_WIDTH = 32;
    localparam int OFF_EXT_W    = OFFSET_WIDTH + 32;

    localparam logic [31:0] RIFF_MAGIC = 32'h52494646;
    localparam logic [31:0] WAVE_MAGIC = 32'h57415645;
    localparam logic [31:0] ID_FMT     = 32'h666D7420;
    localparam logic [31:0] ID_DATA    = 32'h64617461;

    localparam int MIN_FILE_BYTES = 44;
    localparam int FMT_MIN_LEN    = 16;
    localparam int PCM_BITS       = 16;
    localparam int RIFF_HDR_LAST  = 11;

    // Byte positions inside an eight-byte chunk header.
    localparam logic [2:0] HDR_ID_LAST  = 3'd3;
    localparam logic [2:0] HDR_LEN_LAST = 3'd7;

    // Frame count division: 31-bit dividend, one quotient bit per cycle.
    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        PH_RIFF,
        PH_HDR,
        PH_BODY,
        PH_PAD
    } walk_phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_FMT,
        KIND_DATA
    } chunk_kind_t;

    typedef enum logic {
        ST_RUN,
        ST_DIVIDE
    } ctrl_state_t;

    typedef struct packed {
        logic byte_en;
        logic riff_byte;
        logic id_shift;
        logic len_shift;
        logic kind_load;
        logic body_byte;
        logic cursor_clr;
        logic cursor_inc;
        logic commit;
        logic file_end;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       off_ge_11;
        logic [2:0] hdr_pos;
        logic       len_zero;
        logic       len_odd;
        logic       body_end;
        logic       div_done;
    } dp_stat_t;

    // Byte idx of a four-character code, first character at index 0.
    function automatic logic [7:0] magic_byte(input logic [31:0] word,
                                              input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = word[31:24];
            2'd1: b = word[23:16];
            2'd2: b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* design/wrp_divider.sv */
`default_nettype none

module wrp_divider import wrp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [30:0] dividend,
    input  wire logic [15:0] divisor,
    output logic      [30:0] quotient,
    output logic             done
);

    logic [30:0]          quo_reg, quo_next;
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          dvs_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [16:0]          trial;
    logic                 fits;

    // Restoring division: the remainder stays below the divisor.
    always_comb begin
        trial    = {rem_reg, quo_reg[30]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
        quo_next = {quo_reg[29:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && count_reg == '0) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg   <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
            count_reg <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (busy_reg) begin
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            count_reg <= count_reg - DIV_CNT_W'(1);
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

/* design/wrp_datapath.sv */
`default_nettype none

module wrp_datapath import wrp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire logic [7:0]  s_file_byte,
    output dp_stat_t         stat,
    output logic             m_header_ok,
    output logic [15:0]      m_channel_count,
    output logic [30:0]      m_sampling_rate,
    output logic [31:0]      m_data_start,
    output logic [31:0]      m_data_bytes,
    output logic [30:0]      m_frame_count
);

    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic                    magic_ok_reg, magic_ok_next;
    logic [31:0]             cursor_reg, cursor_next;
    logic [31:0]             length_reg, len_eff;
    chunk_kind_t             kind_reg, kind_next;
    logic [31:0]             id_reg, id_next;
    logic [15:0]             pend_ch_reg, pend_ch_next;
    logic [31:0]             pend_rate_reg, pend_rate_next;
    logic [15:0]             pend_bits_reg, pend_bits_next;
    logic [15:0]             kept_ch_reg, kept_ch_next;
    logic [31:0]             kept_rate_reg, kept_rate_next;
    logic [15:0]             kept_bits_reg, kept_bits_next;
    logic                    data_seen_reg, data_seen_next;
    logic [31:0]             kept_start_reg, kept_start_next;
    logic [31:0]             kept_bytes_reg, kept_bytes_next;

    logic                    stage_ok_reg, stage_ok_next;
    logic [15:0]             stage_ch_reg;
    logic [30:0]             stage_rate_reg;
    logic [31:0]             stage_start_reg;
    logic [31:0]             stage_bytes_reg, stage_bytes_next;

    logic [OFF_EXT_W-1:0]    off_ext;
    logic [31:0]             off32;
    logic [7:0]              want;
    logic                    fmt_take, data_take;
    logic [30:0]             quotient;
    logic                    div_done;

    always_comb begin
        id_next  = cmd.id_shift ? {id_reg[23:0], s_file_byte} : id_reg;
        len_eff  = cmd.len_shift ? {s_file_byte, length_reg[31:8]} : length_reg;

        kind_next = kind_reg;
        if (cmd.kind_load) begin
            if (id_next == ID_FMT) begin
                kind_next = KIND_FMT;
            end else if (id_next == ID_DATA) begin
                kind_next = KIND_DATA;
            end else begin
                kind_next = KIND_OTHER;
            end
        end

        // Format fields sit at fixed body positions of a fmt chunk.
        pend_ch_next   = pend_ch_reg;
        pend_rate_next = pend_rate_reg;
        pend_bits_next = pend_bits_reg;
        if (cmd.body_byte && kind_reg == KIND_FMT && cursor_reg[31:4] == '0) begin
            unique case (cursor_reg[3:0])
                4'd2:    pend_ch_next[7:0]     = s_file_byte;
                4'd3:    pend_ch_next[15:8]    = s_file_byte;
                4'd4:    pend_rate_next[7:0]   = s_file_byte;
                4'd5:    pend_rate_next[15:8]  = s_file_byte;
                4'd6:    pend_rate_next[23:16] = s_file_byte;
                4'd7:    pend_rate_next[31:24] = s_file_byte;
                4'd14:   pend_bits_next[7:0]   = s_file_byte;
                4'd15:   pend_bits_next[15:8]  = s_file_byte;
                default: ;
            endcase
        end

        want          = magic_byte(RIFF_MAGIC, offset_reg[1:0]);
        magic_ok_next = magic_ok_reg;
        if (cmd.riff_byte) begin
            if (offset_reg < OFFSET_WIDTH'(4)) begin
                want = magic_byte(RIFF_MAGIC, offset_reg[1:0]);
                if (s_file_byte != want) begin
                    magic_ok_next = 1'b0;
                end
            end else if (offset_reg >= OFFSET_WIDTH'(8) &&
                         offset_reg <= OFFSET_WIDTH'(RIFF_HDR_LAST)) begin
                want = magic_byte(WAVE_MAGIC, offset_reg[1:0]);
                if (s_file_byte != want) begin
                    magic_ok_next = 1'b0;
                end
            end
        end

        off_ext = OFF_EXT_W'(offset_reg);
        off32   = off_ext[31:0];

        fmt_take  = cmd.commit && kind_reg == KIND_FMT && len_eff >= 32'(FMT_MIN_LEN);
        data_take = cmd.commit && kind_reg == KIND_DATA;

        kept_ch_next    = fmt_take ? pend_ch_next   : kept_ch_reg;
        kept_rate_next  = fmt_take ? pend_rate_next : kept_rate_reg;
        kept_bits_next  = fmt_take ? pend_bits_next : kept_bits_reg;
        data_seen_next  = data_take ? 1'b1 : data_seen_reg;
        kept_start_next = data_take ? off32 + 32'd1 - len_eff : kept_start_reg;
        kept_bytes_next = data_take ? len_eff : kept_bytes_reg;

        if (cmd.cursor_clr) begin
            cursor_next = '0;
        end else if (cmd.cursor_inc) begin
            cursor_next = cursor_reg + 32'd1;
        end else begin
            cursor_next = cursor_reg;
        end

        offset_next = offset_reg;
        if (cmd.byte_en && offset_reg != '1) begin
            offset_next = offset_reg + OFFSET_WIDTH'(1);
        end

        stage_ok_next = offset_reg >= OFFSET_WIDTH'(MIN_FILE_BYTES - 1) &&
                        magic_ok_next && data_seen_next &&
                        kept_ch_next != '0 && kept_rate_next != '0 &&
                        !kept_rate_next[31] && kept_bits_next == 16'(PCM_BITS);
        stage_bytes_next = stage_ok_next ? kept_bytes_next : '0;
    end

    // Parse state returns to its reset values after the final byte.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.file_end) begin
            offset_reg     <= '0;
            magic_ok_reg   <= 1'b1;
            cursor_reg     <= '0;
            length_reg     <= '0;
            kind_reg       <= KIND_OTHER;
            id_reg         <= '0;
            pend_ch_reg    <= '0;
            pend_rate_reg  <= '0;
            pend_bits_reg  <= '0;
            kept_ch_reg    <= '0;
            kept_rate_reg  <= '0;
            kept_bits_reg  <= '0;
            data_seen_reg  <= 1'b0;
            kept_start_reg <= '0;
            kept_bytes_reg <= '0;
        end else begin
            offset_reg     <= offset_next;
            magic_ok_reg   <= magic_ok_next;
            cursor_reg     <= cursor_next;
            length_reg     <= len_eff;
            kind_reg       <= kind_next;
            id_reg         <= id_next;
            pend_ch_reg    <= pend_ch_next;
            pend_rate_reg  <= pend_rate_next;
            pend_bits_reg  <= pend_bits_next;
            kept_ch_reg    <= kept_ch_next;
            kept_rate_reg  <= kept_rate_next;
            kept_bits_reg  <= kept_bits_next;
            data_seen_reg  <= data_seen_next;
            kept_start_reg <= kept_start_next;
            kept_bytes_reg <= kept_bytes_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.file_end) begin
            stage_ok_reg    <= stage_ok_next;
            stage_ch_reg    <= stage_ok_next ? kept_ch_next : '0;
            stage_rate_reg  <= stage_ok_next ? kept_rate_next[30:0] : '0;
            stage_start_reg <= stage_ok_next ? kept_start_next : '0;
            stage_bytes_reg <= stage_bytes_next;
        end
    end

    wrp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.file_end),
        .dividend (stage_bytes_next[31:1]),
        .divisor  (stage_ok_next ? kept_ch_next : 16'd1),
        .quotient (quotient),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_header_ok     <= stage_ok_reg;
            m_channel_count <= stage_ch_reg;
            m_sampling_rate <= stage_rate_reg;
            m_data_start    <= stage_start_reg;
            m_data_bytes    <= stage_bytes_reg;
            m_frame_count   <= stage_ok_reg ? quotient : '0;
        end
    end

    assign stat.off_ge_11 = offset_reg >= OFFSET_WIDTH'(RIFF_HDR_LAST);
    assign stat.hdr_pos   = cursor_reg[2:0];
    assign stat.len_zero  = len_eff == '0;
    assign stat.len_odd   = len_eff[0];
    assign stat.body_end  = ({1'b0, cursor_reg} + 33'd1) == {1'b0, length_reg};
    assign stat.div_done  = div_done;

endmodule

`default_nettype wire

/* design/wrp_ctrl.sv */
`default_nettype none

module wrp_ctrl import wrp_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_last_byte,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output logic          s_ready,
    output logic          m_valid,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    walk_phase_t phase_reg, phase_next;
    logic        m_valid_reg, m_valid_next;
    logic        accept;
    logic        hdr_end;

    assign accept  = s_valid && s_ready;
    assign hdr_end = stat.hdr_pos == HDR_LEN_LAST;

    // Next state of the block sequencer and of the chunk walk.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (accept && s_last_byte) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (cmd.out_load) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase

        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_RIFF: begin
                    if (stat.off_ge_11) begin
                        phase_next = PH_HDR;
                    end
                end
                PH_HDR: begin
                    if (hdr_end) begin
                        phase_next = stat.len_zero ? PH_HDR : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (stat.body_end) begin
                        phase_next = stat.len_odd ? PH_PAD : PH_HDR;
                    end
                end
                default: phase_next = PH_HDR;
            endcase
            if (s_last_byte) begin
                phase_next = PH_RIFF;
            end
        end
    end

    // Datapath commands and handshake outputs.
    always_comb begin
        s_ready = state_reg == ST_RUN;
        cmd     = '0;

        cmd.byte_en  = accept;
        cmd.file_end = accept && s_last_byte;
        cmd.out_load = state_reg == ST_DIVIDE && stat.div_done &&
                       (!m_valid_reg || m_ready);

        unique case (phase_reg)
            PH_RIFF: begin
                cmd.riff_byte  = accept;
                cmd.cursor_clr = accept && stat.off_ge_11;
            end
            PH_HDR: begin
                cmd.id_shift   = accept && !stat.hdr_pos[2];
                cmd.len_shift  = accept && stat.hdr_pos[2];
                cmd.kind_load  = accept && stat.hdr_pos == HDR_ID_LAST;
                cmd.cursor_inc = accept;
                cmd.cursor_clr = accept && hdr_end;
                cmd.commit     = accept && hdr_end && stat.len_zero;
            end
            PH_BODY: begin
                cmd.body_byte  = accept;
                cmd.cursor_inc = accept;
                cmd.cursor_clr = accept && stat.body_end;
                cmd.commit     = accept && stat.body_end;
            end
            default: begin
                cmd.cursor_clr = accept;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        m_valid = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            phase_reg   <= PH_RIFF;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* design/wav_riff_header_parser.sv */
// Channel   Direction  Handshake          Beat contents
// s_        in         s_valid/s_ready    s_file_byte, s_last_byte
// m_        out        m_valid/m_ready    m_header_ok, m_channel_count, m_sampling_rate,
//                                         m_data_start, m_data_bytes, m_frame_count
//
// File bytes are taken one per cycle while s_ready is high. The beat with
// s_last_byte set ends the file: the block then runs the bit-serial frame
// count divider (31 quotient bits, one per cycle) with s_ready low, and is
// ready for the next file as soon as the result sits in the output register.
// A result waiting on m_ready does not block the next file; only a second
// finished file stalls until the first result has been taken.
// Reset is synchronous and active low and needs no clearing pass.
`default_nettype none

module wav_riff_header_parser import wrp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_file_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_header_ok,
    output logic [15:0]      m_channel_count,
    output logic [30:0]      m_sampling_rate,
    output logic [31:0]      m_data_start,
    output logic [31:0]      m_data_bytes,
    output logic [30:0]      m_frame_count
);

    // The controller owns the chunk walk phase and the block sequence; the
    // datapath owns offsets, cursors, collected fields and the divider.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    wrp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .m_ready     (m_ready),
        .stat        (stat),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .cmd         (cmd)
    );

    // A chunk commits on the byte that completes its body, so fields that
    // arrive on that same byte are already part of the committed values.
    wrp_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_file_byte     (s_file_byte),
        .stat            (stat),
        .m_header_ok     (m_header_ok),
        .m_channel_count (m_channel_count),
        .m_sampling_rate (m_sampling_rate),
        .m_data_start    (m_data_start),
        .m_data_bytes    (m_data_bytes),
        .m_frame_count   (m_frame_count)
    );

endmodule

`default_nettype wire

/* design/wrp_checker.sv */
`default_nettype none

module wrp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_file_byte,
    input wire logic        s_last_byte,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_header_ok,
    input wire logic [15:0] m_channel_count,
    input wire logic [30:0] m_sampling_rate,
    input wire logic [31:0] m_data_start,
    input wire logic [31:0] m_data_bytes,
    input wire logic [30:0] m_frame_count
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_header_ok) &&
        $stable(m_channel_count) && $stable(m_data_bytes) && $stable(m_frame_count))
        else $error("result beat changed while stalled");

    // The end of a file always starts the divider, which holds off input.
    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_byte |=> !s_ready)
        else $error("input accepted right after end of file");

    // A rejected header reports nothing but zeros.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_header_ok |-> m_channel_count == '0 && m_sampling_rate == '0 &&
        m_data_start == '0 && m_data_bytes == '0 && m_frame_count == '0)
        else $error("rejected header carries nonzero fields");

    // An accepted header has channels and a sample rate.
    a_good_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_header_ok |-> m_channel_count != '0 && m_sampling_rate != '0)
        else $error("accepted header without format");

    // No result beat right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat after reset");

endmodule

bind wav_riff_header_parser wrp_checker u_wrp_checker (.*);

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

// Testbench for the RIFF WAVE header parser. Files are streamed one byte per
// beat with random gaps, a header summary is predicted for every file when
// its last byte is accepted, and each summary beat from the block is compared
// field by field against the oldest prediction.
module tb import wrp_pkg::*; ();

    localparam int           MAX_GAP        = 19;
    localparam int           RANDOM_BYTES   = 900;
    localparam int           MIN_RAND_FILES = 10;
    // Wait for the divider after the last byte; leave plenty of slack.
    localparam int           TAIL_CYCLES    = 80;
    localparam int           CYCLE_LIMIT    = 400000;
    localparam logic [31:0]  ID_LIST        = 32'h4C495354;
    localparam logic [31:0]  ID_JUNK        = 32'h4A554E4B;

    // One header summary as the result channel presents it.
    typedef struct packed {
        logic        ok;
        logic [15:0] channels;
        logic [30:0] rate;
        logic [31:0] start;
        logic [31:0] nbytes;
        logic [30:0] frames;
    } wav_summary_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_file_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_header_ok;
    logic [15:0] m_channel_count;
    logic [30:0] m_sampling_rate;
    logic [31:0] m_data_start;
    logic [31:0] m_data_bytes;
    logic [30:0] m_frame_count;

    wav_riff_header_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_header_ok     (m_header_ok),
        .m_channel_count (m_channel_count),
        .m_sampling_rate (m_sampling_rate),
        .m_data_start    (m_data_start),
        .m_data_bytes    (m_data_bytes),
        .m_frame_count   (m_frame_count)
    );

    // Summaries predicted for files whose last byte has been accepted but
    // whose result beat has not yet been seen.
    wav_summary_t summary_q[$];
    // The file currently being built for transmission.
    logic [7:0]   file_q[$];

    int  err_cnt     = 0;
    int  bytes_sent  = 0;
    int  cycle_cnt   = 0;
    bit  s_idle_en   = 1'b1;
    bit  rd_idle_en  = 1'b1;
    int  rd_hold     = 0;

    // Shadow copy of the parser state.
    logic [OFFSET_WIDTH-1:0] pos;
    bit                      magic_good;
    walk_phase_t             phase;
    logic [31:0]             cur;
    logic [31:0]             ck_len;
    logic [31:0]             ck_id;
    chunk_kind_t             ck_kind;
    logic [15:0]             new_ch;
    logic [31:0]             new_rate;
    logic [15:0]             new_bits;
    logic [15:0]             fmt_ch;
    logic [31:0]             fmt_rate;
    logic [15:0]             fmt_bits;
    bit                      have_data;
    logic [31:0]             data_off;
    logic [31:0]             data_len;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs or loses a result.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Appends one byte to the end of the file under construction.
    task automatic append_byte(input logic [7:0] v);
        file_q.insert(file_q.size(), v);
    endtask

    task automatic parser_clear();
        pos        = '0;
        magic_good = 1'b1;
        phase      = PH_RIFF;
        cur        = '0;
        ck_len     = '0;
        ck_id      = '0;
        ck_kind    = KIND_OTHER;
        new_ch     = '0;
        new_rate   = '0;
        new_bits   = '0;
        fmt_ch     = '0;
        fmt_rate   = '0;
        fmt_bits   = '0;
        have_data  = 1'b0;
        data_off   = '0;
        data_len   = '0;
    endtask

    // A chunk body has just completed on the current byte: keep what it
    // carries and step to the pad byte or the next chunk header.
    task automatic accept_chunk();
        logic [63:0] body_at;
        if (ck_kind == KIND_FMT && ck_len >= FMT_MIN_LEN) begin
            fmt_ch   = new_ch;
            fmt_rate = new_rate;
            fmt_bits = new_bits;
        end else if (ck_kind == KIND_DATA) begin
            have_data = 1'b1;
            body_at   = 64'(pos) + 64'd1 - 64'(ck_len);
            data_off  = body_at[31:0];
            data_len  = ck_len;
        end
        cur   = '0;
        phase = ck_len[0] ? PH_PAD : PH_HDR;
    endtask

    // Advances the shadow parser by one accepted byte. On the last byte of a
    // file the predicted summary is queued and the shadow parser rearms.
    task automatic parse_byte(input logic [7:0] b, input bit last);
        wav_summary_t sum;
        logic [31:0]  quot;
        int           sh;
        case (phase)
            PH_RIFF: begin
                sh = 8 * (3 - int'(pos[1:0]));
                if (pos < 4 && b != RIFF_MAGIC[sh +: 8])
                    magic_good = 1'b0;
                else if (pos >= 8 && pos < 12 && b != WAVE_MAGIC[sh +: 8])
                    magic_good = 1'b0;
                if (pos >= RIFF_HDR_LAST) begin
                    phase = PH_HDR;
                    cur   = '0;
                end
            end
            PH_HDR: begin
                // Four id bytes shift in big-end first, then the length
                // arrives little-endian.
                if (cur < 4)
                    ck_id = {ck_id[23:0], b};
                else
                    ck_len = {b, ck_len[31:8]};
                cur++;
                if (cur == 4) begin
                    if (ck_id == ID_FMT)
                        ck_kind = KIND_FMT;
                    else if (ck_id == ID_DATA)
                        ck_kind = KIND_DATA;
                    else
                        ck_kind = KIND_OTHER;
                end else if (cur >= 8) begin
                    cur = '0;
                    // A zero-length chunk is taken as soon as its header ends.
                    if (ck_len == 0)
                        accept_chunk();
                    else
                        phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (ck_kind == KIND_FMT) begin
                    case (cur)
                        2:          new_ch[7:0]               = b;
                        3:          new_ch[15:8]              = b;
                        4, 5, 6, 7: new_rate[8*(cur-4) +: 8]  = b;
                        14:         new_bits[7:0]             = b;
                        15:         new_bits[15:8]            = b;
                        default: ;
                    endcase
                end
                cur++;
                if (cur >= ck_len)
                    accept_chunk();
            end
            default: begin
                phase = PH_HDR;
                cur   = '0;
            end
        endcase

        if (!last) begin
            if (pos != {OFFSET_WIDTH{1'b1}})
                pos++;
        end else begin
            sum = '0;
            if (64'(pos) + 64'd1 >= MIN_FILE_BYTES && magic_good && have_data &&
                fmt_ch != 0 && fmt_rate != 0 && fmt_rate <= 32'h7FFF_FFFF &&
                fmt_bits == PCM_BITS) begin
                quot         = (data_len / 2) / {16'd0, fmt_ch};
                sum.ok       = 1'b1;
                sum.channels = fmt_ch;
                sum.rate     = fmt_rate[30:0];
                sum.start    = data_off;
                sum.nbytes   = data_len;
                sum.frames   = quot[30:0];
            end
            summary_q.insert(summary_q.size(), sum);
            parser_clear();
        end
    endtask

    // Sends one byte beat. Called and returns at a falling edge; valid only
    // drops when a gap is drawn, so back-to-back beats keep it high.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = s_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_file_byte = b;
        s_last_byte = last;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_file();
        foreach (file_q[i])
            send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    // Holds the sender off until every predicted summary has been received.
    task automatic wait_all_summaries();
        s_valid = 1'b0;
        while (summary_q.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic push_tag(input logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            append_byte(tag[8*i +: 8]);
    endtask

    task automatic push_le32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            append_byte(v[8*i +: 8]);
    endtask

    task automatic push_riff();
        push_tag(RIFF_MAGIC);
        push_le32($urandom);
        push_tag(WAVE_MAGIC);
    endtask

    // A format chunk; the format tag is 1, channels, rate and bits sit at their
    // usual offsets, and the rest of the body is filler.
    task automatic push_fmt(input int len, input logic [15:0] ch,
                            input logic [31:0] rate, input logic [15:0] bits,
                            input bit pad);
        logic [7:0] v;
        push_tag(ID_FMT);
        push_le32(len);
        for (int i = 0; i < len; i++) begin
            case (i)
                0:          v = 8'h01;
                1:          v = 8'h00;
                2:          v = ch[7:0];
                3:          v = ch[15:8];
                4, 5, 6, 7: v = rate[8*(i-4) +: 8];
                14:         v = bits[7:0];
                15:         v = bits[15:8];
                default:    v = 8'($urandom);
            endcase
            append_byte(v);
        end
        if (len % 2 == 1 && pad)
            append_byte(8'($urandom));
    endtask

    // Any other chunk, data included, with a random body.
    task automatic push_chunk(input logic [31:0] id, input int len, input bit pad);
        push_tag(id);
        push_le32(len);
        repeat (len)
            append_byte(8'($urandom));
        if (len % 2 == 1 && pad)
            append_byte(8'($urandom));
    endtask

    // The result side stalls for a drawn number of cycles once each result
    // is offered; the count only runs down while m_valid is high.
    initial begin
        m_ready = 1'b0;
        rd_hold = $urandom_range(0, MAX_GAP);
        forever begin
            @(negedge aclk);
            if (rd_hold > 0) begin
                m_ready = 1'b0;
                if (m_valid)
                    rd_hold--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge aclk) begin
        wav_summary_t want;
        if (aresetn && m_valid && m_ready) begin
            if (summary_q.size() == 0) begin
                $error("result beat arrived with no file pending");
                err_cnt++;
            end else begin
                want = summary_q.pop_front();
                check_field("header_ok", 32'(want.ok), 32'(m_header_ok));
                check_field("channel_count", 32'(want.channels), 32'(m_channel_count));
                check_field("sampling_rate", 32'(want.rate), 32'(m_sampling_rate));
                check_field("data_start", want.start, m_data_start);
                check_field("data_bytes", want.nbytes, m_data_bytes);
                check_field("frame_count", 32'(want.frames), 32'(m_frame_count));
            end
            if ($urandom_range(0, 7) == 0)
                rd_idle_en = ~rd_idle_en;
            rd_hold = rd_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        end
    end

    // The smallest legal file (44 bytes, empty data chunk) and a typical
    // mono file with a short data body.
    task automatic test_minimal_pcm();
        s_idle_en = 1'b1;
        file_q.delete();
        push_riff();
        push_fmt(16, 16'd2, 32'd44100, 16'd16, 1'b1);
        push_chunk(ID_DATA, 0, 1'b1);
        send_file();
        file_q.delete();
        push_riff();
        push_fmt(16, 16'd1, 32'd8000, 16'd16, 1'b1);
        push_chunk(ID_DATA, 8, 1'b1);
        send_file();
        wait_all_summaries();
    endtask

    // One-byte files at both byte extremes, and a file one byte short of
    // the minimum whose data header is cut off.
    task automatic test_short_files();
        file_q.delete();
        append_byte(8'h00);
        send_file();
        file_q.delete();
        append_byte(8'hFF);
        send_file();
        file_q.delete();
        push_riff();
        push_fmt(16, 16'd2, 32'd48000, 16'd16, 1'b1);
        push_chunk(ID_DATA, 0, 1'b1);
        void'(file_q.pop_back());
        send_file();
        wait_all_summaries();
    endtask

    // The walk still runs with a bad magic, but the file must be rejected.
    task automatic test_bad_magic();
        file_q.delete();
        push_riff();
        push_fmt(16, 16'd1, 32'd22050, 16'd16, 1'b1);
        push_chunk(ID_DATA, 4, 1'b1);
        file_q[0] = 8'h72;
        send_file();
        file_q[0]  = RIFF_MAGIC[31:24];
        file_q[11] = 8'h46;
        send_file();
        wait_all_summaries();
    endtask

    // Odd chunks with pad bytes, an empty chunk, a short format chunk that
    // must be ignored, later chunks overriding earlier ones, and a final odd
    // data chunk whose pad byte falls past the end of the file.
    task automatic test_chunk_override();
        file_q.delete();
        push_riff();
        push_chunk(ID_LIST, 3, 1'b1);
        push_chunk(ID_JUNK, 0, 1'b1);
        push_fmt(14, 16'd5, 32'd96000, 16'd16, 1'b1);
        push_fmt(16, 16'd1, 32'd8000, 16'd8, 1'b1);
        push_fmt(18, 16'hFFFF, 32'h7FFF_FFFF, 16'd16, 1'b1);
        push_chunk(ID_DATA, 5, 1'b1);
        push_chunk(ID_DATA, 2, 1'b1);
        push_chunk(ID_DATA, 7, 1'b0);
        send_file();
        wait_all_summaries();
    endtask

    // A data chunk whose body runs past the end of the file is never taken,
    // so the earlier data chunk stands.
    task automatic test_truncated_chunk();
        file_q.delete();
        push_riff();
        push_fmt(16, 16'd2, 32'd44100, 16'd16, 1'b1);
        push_chunk(ID_DATA, 12, 1'b1);
        push_tag(ID_DATA);
        push_le32(32'd1000);
        repeat (3)
            append_byte(8'($urandom));
        send_file();
        wait_all_summaries();
    endtask

    // Mostly well-formed files with random chunk order and field values,
    // some cut short or with a damaged magic, plus raw noise files.
    task automatic test_random_files();
        int          plan[$];
        int          start_bytes;
        int          nfiles;
        int          sel;
        int          n;
        int          j;
        int          tmp;
        int          len;
        int          cut;
        bit          broken;
        bit          stop;
        bit          at_end;
        logic [15:0] ch;
        logic [31:0] rate;
        logic [15:0] bits;
        start_bytes = bytes_sent;
        nfiles      = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES || nfiles < MIN_RAND_FILES) begin
            s_idle_en = ($urandom_range(0, 3) != 0);
            file_q.delete();
            sel = $urandom_range(0, 99);
            if (sel >= 85) begin
                len = $urandom_range(1, 40);
                if ($urandom_range(0, 2) == 0)
                    push_tag(RIFF_MAGIC);
                while (file_q.size() < len)
                    append_byte(8'($urandom));
            end else begin
                broken = (sel >= 70);
                push_riff();
                plan.delete();
                if ($urandom_range(0, 9) != 0)
                    plan.insert(plan.size(), 0);
                if ($urandom_range(0, 9) != 0)
                    plan.insert(plan.size(), 1);
                n = $urandom_range(0, 2);
                repeat (n)
                    plan.insert(plan.size(), 2);
                if ($urandom_range(0, 3) == 0)
                    plan.insert(plan.size(), $urandom_range(0, 1));
                for (int i = plan.size() - 1; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = plan[i];
                    plan[i] = plan[j];
                    plan[j] = tmp;
                end
                stop = 1'b0;
                foreach (plan[i]) begin
                    if (!stop) begin
                        at_end = (i == plan.size() - 1);
                        case (plan[i])
                            0: begin
                                sel = $urandom_range(0, 9);
                                len = (sel < 6) ? 16 : (sel == 6) ? 18 : (sel == 7) ? 14 :
                                      (sel == 8) ? 17 : $urandom_range(0, 30);
                                sel = $urandom_range(0, 9);
                                ch  = (sel < 5) ? 16'($urandom_range(1, 2)) :
                                      (sel == 5) ? 16'd0 : (sel == 6) ? 16'hFFFF :
                                      16'($urandom);
                                sel  = $urandom_range(0, 9);
                                rate = (sel < 5) ? 32'd44100 : (sel == 5) ? 32'd0 :
                                       (sel == 6) ? 32'h7FFF_FFFF :
                                       (sel == 7) ? (32'h8000_0000 | $urandom) : $urandom;
                                sel  = $urandom_range(0, 9);
                                bits = (sel < 7) ? 16'd16 : (sel == 7) ? 16'd8 :
                                       (sel == 8) ? 16'd24 : 16'($urandom);
                                push_fmt(len, ch, rate, bits,
                                         !at_end || $urandom_range(0, 1) == 1);
                            end
                            1: begin
                                if ($urandom_range(0, 11) == 0) begin
                                    // Declared far longer than anything sent:
                                    // the file ends inside this body.
                                    push_tag(ID_DATA);
                                    push_le32($urandom | 32'h0000_0100);
                                    n = $urandom_range(0, 8);
                                    repeat (n)
                                        append_byte(8'($urandom));
                                    stop = 1'b1;
                                end else begin
                                    len = ($urandom_range(0, 9) == 0) ?
                                          $urandom_range(49, 120) : $urandom_range(0, 48);
                                    push_chunk(ID_DATA, len,
                                               !at_end || $urandom_range(0, 1) == 1);
                                end
                            end
                            default: begin
                                sel = $urandom_range(0, 4);
                                push_chunk((sel == 0) ? ID_LIST :
                                           (sel == 1) ? (ID_FMT ^ (32'd1 << $urandom_range(0, 31))) :
                                           (sel == 2) ? (ID_DATA ^ (32'd1 << $urandom_range(0, 31))) :
                                           (sel == 3) ? ID_JUNK : $urandom,
                                           $urandom_range(0, 12),
                                           !at_end || $urandom_range(0, 1) == 1);
                            end
                        endcase
                    end
                end
                if (broken ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 11) == 0)) begin
                    j = $urandom_range(0, 7);
                    j = (j < 4) ? j : j + 4;
                    file_q[j] = file_q[j] ^ 8'(1 << $urandom_range(0, 7));
                end
                if (broken) begin
                    cut = $urandom_range(1, file_q.size());
                    while (file_q.size() > cut)
                        void'(file_q.pop_back());
                end else if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(1, 9);
                    repeat (n)
                        append_byte(8'($urandom));
                end
            end
            send_file();
            nfiles++;
            if ($urandom_range(0, 19) == 0)
                wait_all_summaries();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_file_byte = 8'h00;
        s_last_byte = 1'b0;
        parser_clear();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_minimal_pcm();
        test_short_files();
        test_bad_magic();
        test_chunk_override();
        test_truncated_chunk();
        test_random_files();

        // Let the last divide finish and catch any stray result beats.
        wait_all_summaries();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* wav_riff_header_parser.f */
design/wrp_pkg.sv
design/wrp_divider.sv
design/wrp_datapath.sv
design/wrp_ctrl.sv
design/wav_riff_header_parser.sv
design/wrp_checker.sv
test/tb.sv
